// File: hdl/nfpc_pkg.sv
// nfpc_pkg: shared types and constants for the nearest free point claim core
// no dependencies; used by nfpc_dist and nearest_free_point_claim_core
`default_nettype none

package nfpc_pkg;

  // field widths fixed by the transaction format
  localparam int COORD_W = 24;
  localparam int IDX_W   = 6;

  // distance arithmetic widths
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int DIST_W  = SQ_W + 2;

  // register stages inside the distance unit
  localparam int DIST_STAGES = 3;

  // function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef logic signed [COORD_W-1:0] nfpc_coord_t;

  typedef struct packed {
    nfpc_coord_t x;
    nfpc_coord_t y;
    nfpc_coord_t z;
  } nfpc_pt_t;

  // one memory word: claim mark and coordinates
  typedef struct packed {
    logic     used;
    nfpc_pt_t pt;
  } nfpc_entry_t;

  typedef struct packed {
    logic        func;
    nfpc_coord_t point_x;
    nfpc_coord_t point_y;
    nfpc_coord_t point_z;
    nfpc_coord_t query_x;
    nfpc_coord_t query_y;
    nfpc_coord_t query_z;
    logic        search_far;
  } nfpc_in_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] point_index;
    nfpc_coord_t      target_x;
    nfpc_coord_t      target_y;
    nfpc_coord_t      target_z;
  } nfpc_out_t;

endpackage

`default_nettype wire

// File: hdl/nfpc_dist.sv
// nfpc_dist: three-stage pipelined squared euclidean distance unit
// carries an opaque tag alongside each candidate; depends on nfpc_pkg
`default_nettype none

module nfpc_dist #(
  parameter int TAG_W = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        valid_in,
  input  wire logic [TAG_W-1:0]            tag_in,
  input  wire nfpc_pkg::nfpc_pt_t          query,
  input  wire nfpc_pkg::nfpc_pt_t          point,
  output logic                             valid_out,
  output logic [TAG_W-1:0]                 tag_out,
  output logic [nfpc_pkg::DIST_W-1:0]      dist_out
);

  localparam int DW = nfpc_pkg::DIFF_W;
  localparam int SW = nfpc_pkg::SQ_W;
  localparam int TW = nfpc_pkg::DIST_W;

  // magnitude of a signed coordinate difference
  function automatic logic [DW-1:0] abs_diff(input nfpc_pkg::nfpc_coord_t a,
                                             input nfpc_pkg::nfpc_coord_t b);
    logic [DW-1:0] d;
    d = {a[nfpc_pkg::COORD_W-1], a} - {b[nfpc_pkg::COORD_W-1], b};
    return d[DW-1] ? (~d + DW'(1)) : d;
  endfunction

  logic             v1_r, v2_r, v3_r;
  logic [TAG_W-1:0] tag1_r, tag2_r, tag3_r;
  logic [DW-1:0]    ax_nxt, ay_nxt, az_nxt;
  logic [DW-1:0]    ax_r, ay_r, az_r;
  logic [SW-1:0]    sx_nxt, sy_nxt, sz_nxt;
  logic [SW-1:0]    sx_r, sy_r, sz_r;
  logic [TW-1:0]    dist_nxt;
  logic [TW-1:0]    dist_r;

  // stage arithmetic: differences, squares, sum
  always_comb begin
    ax_nxt   = abs_diff(query.x, point.x);
    ay_nxt   = abs_diff(query.y, point.y);
    az_nxt   = abs_diff(query.z, point.z);
    sx_nxt   = ax_r * ax_r;
    sy_nxt   = ay_r * ay_r;
    sz_nxt   = az_r * az_r;
    dist_nxt = TW'(sx_r) + TW'(sy_r) + TW'(sz_r);
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= valid_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    tag1_r <= tag_in;
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    az_r   <= az_nxt;
    tag2_r <= tag1_r;
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
    sz_r   <= sz_nxt;
    tag3_r <= tag2_r;
    dist_r <= dist_nxt;
  end

  assign valid_out = v3_r;
  assign tag_out   = tag3_r;
  assign dist_out  = dist_r;

endmodule

`default_nettype wire

// File: hdl/nearest_free_point_claim_core.sv
// Nearest free point claim core. A load gives no result. A search strobes its result
// once the scan, the distance pipeline and the claim write-back are through: the point
// memory has one read port, so the scan reads one entry per cycle over all loaded points.
// busy is high meanwhile, so a search holds off further input; loads go back to back.
// Reset (synchronous, active low) empties the table at once, no clearing pass; the receiver
// cannot stall the result strobe.
`default_nettype none

module nearest_free_point_claim_core #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire nfpc_pkg::nfpc_in_t  in_data,
  output logic                     busy,
  output logic                     out_valid,
  output nfpc_pkg::nfpc_out_t      out_data
);

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CW    = AW + 1;
  localparam int EW    = $bits(nfpc_pkg::nfpc_entry_t);
  localparam int TAG_W = AW + EW;
  localparam int IXW   = AW + nfpc_pkg::IDX_W;
  localparam int DRW   = $clog2(nfpc_pkg::DIST_STAGES);
  localparam int TW    = nfpc_pkg::DIST_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         scan_r, scan_nxt;
  logic [DRW-1:0]        drain_r, drain_nxt;
  nfpc_pkg::nfpc_pt_t    query_r, query_nxt;
  logic                  far_r, far_nxt;
  logic                  have_r, have_nxt;
  logic [AW-1:0]         best_idx_r, best_idx_nxt;
  nfpc_pkg::nfpc_pt_t    best_pt_r, best_pt_nxt;
  logic [TW-1:0]         best_d_r, best_d_nxt;
  logic                  out_valid_r, out_valid_nxt;
  nfpc_pkg::nfpc_out_t   out_data_r, out_data_nxt;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  nfpc_pkg::nfpc_entry_t wr_entry;
  logic                  rd_en;
  logic                  clear_best;

  // point memory: claim mark plus coordinates, valid below count_r
  nfpc_pkg::nfpc_entry_t mem [MAX_POINTS];
  nfpc_pkg::nfpc_entry_t rd_q_r;
  logic [AW-1:0]         rd_idx_r;
  logic                  rd_vld_r;

  logic                  cand_vld;
  logic [TAG_W-1:0]      cand_tag;
  logic [TW-1:0]         cand_d;
  nfpc_pkg::nfpc_entry_t cand_entry;
  logic [AW-1:0]         cand_idx;
  logic                  better;
  logic                  take;
  logic [IXW-1:0]        idx_ext;

  // control sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    drain_nxt     = drain_r;
    query_nxt     = query_r;
    far_nxt       = far_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[AW-1:0];
    wr_entry.used = 1'b0;
    wr_entry.pt.x = in_data.point_x;
    wr_entry.pt.y = in_data.point_y;
    wr_entry.pt.z = in_data.point_z;
    rd_en         = 1'b0;
    clear_best    = 1'b0;
    idx_ext       = IXW'(best_idx_r);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_data.func == nfpc_pkg::FUNC_LOAD) begin
            // append unless the table is full
            if (count_r < CW'(MAX_POINTS)) begin
              wr_en     = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end else begin
            query_nxt.x = in_data.query_x;
            query_nxt.y = in_data.query_y;
            query_nxt.z = in_data.query_z;
            far_nxt     = in_data.search_far;
            scan_nxt    = '0;
            clear_best  = 1'b1;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_r == count_r) begin
          drain_nxt = '0;
          state_nxt = ST_DRAIN;
        end else begin
          rd_en    = 1'b1;
          scan_nxt = scan_r + CW'(1);
        end
      end
      ST_DRAIN: begin
        // wait for the last candidate to leave the distance pipeline
        if (drain_r == DRW'(nfpc_pkg::DIST_STAGES - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          drain_nxt = drain_r + DRW'(1);
        end
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        if (have_r) begin
          // claim the winner and report it
          wr_en                    = 1'b1;
          wr_addr                  = best_idx_r;
          wr_entry.used            = 1'b1;
          wr_entry.pt              = best_pt_r;
          out_data_nxt.found       = 1'b1;
          out_data_nxt.point_index = idx_ext[nfpc_pkg::IDX_W-1:0];
          out_data_nxt.target_x    = best_pt_r.x;
          out_data_nxt.target_y    = best_pt_r.y;
          out_data_nxt.target_z    = best_pt_r.z;
        end else begin
          out_data_nxt = '0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r   <= mem[scan_r[AW-1:0]];
      rd_idx_r <= scan_r[AW-1:0];
    end
  end

  // distance pipeline
  nfpc_dist #(
    .TAG_W (TAG_W)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (rd_vld_r),
    .tag_in    ({rd_idx_r, rd_q_r}),
    .query     (query_r),
    .point     (rd_q_r.pt),
    .valid_out (cand_vld),
    .tag_out   (cand_tag),
    .dist_out  (cand_d)
  );

  // best candidate tracking; strict compare keeps the earliest on a tie
  always_comb begin
    cand_entry   = nfpc_pkg::nfpc_entry_t'(cand_tag[EW-1:0]);
    cand_idx     = cand_tag[EW +: AW];
    better       = far_r ? (cand_d > best_d_r) : (cand_d < best_d_r);
    take         = cand_vld && !cand_entry.used && (!have_r || better);
    have_nxt     = have_r;
    best_idx_nxt = best_idx_r;
    best_pt_nxt  = best_pt_r;
    best_d_nxt   = best_d_r;
    if (clear_best) begin
      have_nxt = 1'b0;
    end else if (take) begin
      have_nxt     = 1'b1;
      best_idx_nxt = cand_idx;
      best_pt_nxt  = cand_entry.pt;
      best_d_nxt   = cand_d;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      drain_r     <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      drain_r     <= drain_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_en;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    query_r    <= query_nxt;
    far_r      <= far_nxt;
    best_idx_r <= best_idx_nxt;
    best_pt_r  <= best_pt_nxt;
    best_d_r   <= best_d_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == ST_DONE))
    else $error("result strobe without a finished search");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result strobe while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_claim_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && have_r) |-> (CW'(best_idx_r) < count_r))
    else $error("claim of an unloaded slot");

endmodule

`default_nettype wire
